### hw/rtl/feedback_delay_line_top_assert.svh
// -----------------------------------------------------------------------------
// feedback_delay_line_top_assert.svh
// Assertion macros shared by the feedback delay line RTL. Both sample on the
// rising edge of clock and are switched off while reset is high.
// -----------------------------------------------------------------------------
`ifndef FEEDBACK_DELAY_LINE_TOP_ASSERT_SVH
`define FEEDBACK_DELAY_LINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDL_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/fdl_pkg.sv
// -----------------------------------------------------------------------------
// fdl_pkg
// Widths, register indexes and arithmetic helpers of the feedback delay line.
// -----------------------------------------------------------------------------
`default_nettype none

package fdl_pkg;

   // Ring of delayed samples per channel; the depth must be a power of two.
   localparam int RING_DEPTH  = 131072;
   localparam int POS_BITS    = $clog2(RING_DEPTH);
   localparam int CHANNELS    = 2;
   localparam int CHAN_BITS   = 1;
   localparam int SAMPLE_BITS = 24;
   localparam int ADDR_BITS   = CHAN_BITS + POS_BITS;
   localparam int STORE_DEPTH = CHANNELS * RING_DEPTH;

   // Configuration registers.
   localparam int DELAY_BITS    = 17;
   localparam int GAIN_BITS     = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 17;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DELAY_SAMPLES = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FEEDBACK_GAIN = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DELAY_GAIN    = 2'd2;

   // Q1.15 scaling: products carry a sign bit above the unsigned gain.
   localparam int Q15_SHIFT   = 15;
   localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int SCALED_BITS = PROD_BITS - Q15_SHIFT;
   localparam int SUM_BITS    = SCALED_BITS + 1;

   localparam logic signed [PROD_BITS-1:0] Q15_HALF = PROD_BITS'(16384);

   // Clamp a wide sum to the signed sample range.
   function automatic logic signed [SAMPLE_BITS-1:0] fdl_sat(
      input logic signed [SUM_BITS-1:0] v
   );
      logic [SUM_BITS-SAMPLE_BITS:0] top;
      top = v[SUM_BITS-1:SAMPLE_BITS-1];
      if ((&top) || (~|top)) begin
         return v[SAMPLE_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

### hw/rtl/fdl_interfaces.sv
// -----------------------------------------------------------------------------
// fdl_interfaces
// Valid/ready channels of the feedback delay line: sample in, sample out and
// register writes.
// -----------------------------------------------------------------------------
`default_nettype none

interface fdl_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [fdl_pkg::CHAN_BITS-1:0]           chan;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0]  sample_in;

   modport source (output valid, output chan, output sample_in, input ready);
   modport sink   (input valid, input chan, input sample_in, output ready);
endinterface

interface fdl_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [fdl_pkg::CHAN_BITS-1:0]           chan_out;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0]  sample_out;

   modport source (output valid, output chan_out, output sample_out, input ready);
   modport sink   (input valid, input chan_out, input sample_out, output ready);
endinterface

interface fdl_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [fdl_pkg::CSR_IDX_BITS-1:0]     index;
   logic [fdl_pkg::CSR_DATA_BITS-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/fdl_ram.sv
// -----------------------------------------------------------------------------
// fdl_ram
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write of the same address in one cycle return the old data.
// -----------------------------------------------------------------------------
`default_nettype none

module fdl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/feedback_delay_line_top.sv
// -----------------------------------------------------------------------------
// feedback_delay_line_top
// Per-channel feedback comb delay line over a shared sample store.
// Throughput: one beat per cycle unless rsp_if.ready stalls the output, set by the
// single read and write port of the store. Reset: registers and write positions
// clear at once; the store is then zeroed one entry per cycle with req_if.ready low
// (register writes still taken).
// -----------------------------------------------------------------------------
`default_nettype none

`include "feedback_delay_line_top_assert.svh"

module feedback_delay_line_top (
   input  wire logic  clock,
   input  wire logic  reset,
   fdl_req_if.sink    req_if,
   fdl_rsp_if.source  rsp_if,
   fdl_csr_if.sink    csr_if
);

   // Configuration registers.
   logic [fdl_pkg::DELAY_BITS-1:0]       delay_ff;
   logic [fdl_pkg::GAIN_BITS-1:0]        fb_gain_ff;
   logic signed [fdl_pkg::GAIN_BITS-1:0] dly_gain_ff;

   // Store clearing after reset.
   logic                           clr_busy_ff;
   logic [fdl_pkg::ADDR_BITS-1:0]  clr_addr_ff;

   // Write positions.
   logic [fdl_pkg::POS_BITS-1:0] wp_ff [fdl_pkg::CHANNELS];
   logic [fdl_pkg::POS_BITS-1:0] wp_sel;
   logic [fdl_pkg::POS_BITS-1:0] wp_inc;
   logic [fdl_pkg::POS_BITS-1:0] rp_sel;

   // Handshake.
   logic out_free;
   logic b_adv;
   logic a_adv;
   logic b_leave;
   logic accept;
   logic active;

   // Address stage.
   logic                                   a_valid_ff;
   logic                                   a_active_ff;
   logic [fdl_pkg::CHAN_BITS-1:0]          a_chan_ff;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] a_sample_ff;
   logic [fdl_pkg::POS_BITS-1:0]           a_wp_ff;
   logic [fdl_pkg::POS_BITS-1:0]           a_rp_ff;

   // Arithmetic stage.
   logic                                   b_valid_ff;
   logic                                   b_active_ff;
   logic [fdl_pkg::CHAN_BITS-1:0]          b_chan_ff;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] b_sample_ff;
   logic [fdl_pkg::POS_BITS-1:0]           b_wp_ff;
   logic                                   b_fwd_hit_ff;
   logic                                   b_fwd_hit_in;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] b_fwd_ff;

   // Result register.
   logic                                   rsp_valid_ff;
   logic [fdl_pkg::CHAN_BITS-1:0]          rsp_chan_ff;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] rsp_sample_ff;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] rsp_sample_in;

   // Store ports.
   logic                                   ram_we;
   logic [fdl_pkg::ADDR_BITS-1:0]          ram_waddr;
   logic [fdl_pkg::SAMPLE_BITS-1:0]        ram_wdata;
   logic                                   ram_re;
   logic [fdl_pkg::SAMPLE_BITS-1:0]        ram_rdata;

   // Datapath.
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] delayed;
   logic signed [fdl_pkg::PROD_BITS-1:0]   delayed_ext;
   logic signed [fdl_pkg::PROD_BITS-1:0]   fb_ext;
   logic signed [fdl_pkg::PROD_BITS-1:0]   dg_ext;
   logic signed [fdl_pkg::PROD_BITS-1:0]   fb_prod;
   logic signed [fdl_pkg::PROD_BITS-1:0]   dg_prod;
   logic signed [fdl_pkg::PROD_BITS-1:0]   fb_round;
   logic signed [fdl_pkg::PROD_BITS-1:0]   dg_round;
   logic signed [fdl_pkg::SUM_BITS-1:0]    sample_ext;
   logic signed [fdl_pkg::SUM_BITS-1:0]    fb_scaled;
   logic signed [fdl_pkg::SUM_BITS-1:0]    dg_scaled;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] stored;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] result;

   // ---------------------------------------------------------------- config
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= '0;
         fb_gain_ff  <= '0;
         dly_gain_ff <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            fdl_pkg::CSR_DELAY_SAMPLES: delay_ff    <= csr_if.data[fdl_pkg::DELAY_BITS-1:0];
            fdl_pkg::CSR_FEEDBACK_GAIN: fb_gain_ff  <= csr_if.data[fdl_pkg::GAIN_BITS-1:0];
            fdl_pkg::CSR_DELAY_GAIN:    dly_gain_ff <= csr_if.data[fdl_pkg::GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- clearing
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (&clr_addr_ff) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- handshake
   // Each stage moves on when the one after it is empty or moving too.
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign b_adv        = !b_valid_ff || out_free;
   assign a_adv        = !a_valid_ff || b_adv;
   assign b_leave      = b_valid_ff && out_free;
   assign req_if.ready = a_adv && !clr_busy_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign active       = (delay_ff != '0);

   // The ring depth is a power of two, so positions wrap by truncation.
   assign wp_sel = wp_ff[req_if.chan];
   assign wp_inc = wp_sel + 1'b1;
   assign rp_sel = wp_sel - delay_ff[fdl_pkg::POS_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fdl_pkg::CHANNELS; i++) begin
            wp_ff[i] <= '0;
         end
      end else if (accept && active) begin
         wp_ff[req_if.chan] <= wp_inc;
      end
   end

   // ---------------------------------------------------------------- address stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_adv) begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_active_ff <= active;
         a_chan_ff   <= req_if.chan;
         a_sample_ff <= req_if.sample_in;
         a_wp_ff     <= wp_sel;
         a_rp_ff     <= rp_sel;
      end
   end

   // ---------------------------------------------------------------- store
   // The store is read as a beat enters the arithmetic stage; the beat leaving
   // that stage writes at the same edge, so a matching address is forwarded.
   assign ram_re    = a_valid_ff && b_adv && a_active_ff;
   assign ram_we    = clr_busy_ff || (b_leave && b_active_ff);
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : {b_chan_ff, b_wp_ff};
   assign ram_wdata = clr_busy_ff ? '0 : stored;

   assign b_fwd_hit_in = b_leave && b_active_ff && ({b_chan_ff, b_wp_ff} == {a_chan_ff, a_rp_ff});

   fdl_ram #(
      .WIDTH (fdl_pkg::SAMPLE_BITS),
      .DEPTH (fdl_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr ({a_chan_ff, a_rp_ff}),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- arithmetic stage
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_adv) begin
         b_active_ff  <= a_active_ff;
         b_chan_ff    <= a_chan_ff;
         b_sample_ff  <= a_sample_ff;
         b_wp_ff      <= a_wp_ff;
         b_fwd_hit_ff <= b_fwd_hit_in;
         b_fwd_ff     <= stored;
      end
   end

   assign delayed = b_fwd_hit_ff ? b_fwd_ff : $signed(ram_rdata);

   assign delayed_ext = {{(fdl_pkg::PROD_BITS - fdl_pkg::SAMPLE_BITS){delayed[fdl_pkg::SAMPLE_BITS-1]}},
                         delayed};
   assign fb_ext      = {{(fdl_pkg::PROD_BITS - fdl_pkg::GAIN_BITS){1'b0}}, fb_gain_ff};
   assign dg_ext      = {{(fdl_pkg::PROD_BITS - fdl_pkg::GAIN_BITS){dly_gain_ff[fdl_pkg::GAIN_BITS-1]}},
                         dly_gain_ff};

   assign fb_prod  = delayed_ext * fb_ext;
   assign dg_prod  = delayed_ext * dg_ext;

   // Adding one half and shifting right rounds to nearest, ties upwards.
   assign fb_round = fb_prod + fdl_pkg::Q15_HALF;
   assign dg_round = dg_prod + fdl_pkg::Q15_HALF;

   assign fb_scaled  = {fb_round[fdl_pkg::PROD_BITS-1], fb_round[fdl_pkg::PROD_BITS-1:fdl_pkg::Q15_SHIFT]};
   assign dg_scaled  = {dg_round[fdl_pkg::PROD_BITS-1], dg_round[fdl_pkg::PROD_BITS-1:fdl_pkg::Q15_SHIFT]};
   assign sample_ext = {{(fdl_pkg::SUM_BITS - fdl_pkg::SAMPLE_BITS){b_sample_ff[fdl_pkg::SAMPLE_BITS-1]}},
                        b_sample_ff};

   assign stored = fdl_pkg::fdl_sat(sample_ext + fb_scaled);
   assign result = fdl_pkg::fdl_sat(sample_ext - dg_scaled);

   assign rsp_sample_in = b_active_ff ? result : b_sample_ff;

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_leave) begin
         rsp_chan_ff   <= b_chan_ff;
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.chan_out   = rsp_chan_ff;
   assign rsp_if.sample_out = rsp_sample_ff;

   // ---------------------------------------------------------------- assertions
   `FDL_ASSERT_IMPLY(a_no_accept_clearing, accept, !clr_busy_ff, "beat accepted while the store is cleared")
   `FDL_ASSERT_NEXT(a_wp_step, accept && active && (req_if.chan == '0), wp_ff[0] == $past(wp_inc), "write position did not advance by one")
   `FDL_ASSERT_NEXT(a_stall_holds, b_valid_ff && !out_free, b_valid_ff && $stable(b_wp_ff) && $stable(b_sample_ff), "stalled beat lost its state")
   `FDL_ASSERT_IMPLY(a_rsp_source, $rose(rsp_valid_ff), $past(b_valid_ff), "result without a beat in the arithmetic stage")

endmodule

`default_nettype wire

### bench/feedback_delay_line_top_tb.sv
// -----------------------------------------------------------------------------
// feedback_delay_line_top_tb
// Self-checking bench for the per-channel feedback comb delay line. A shadow
// model of the delay ring predicts every output beat. Directed samples cover
// bypass, the sample and gain extremes, feedback above unity and the longest
// delay. Random phases then change the register settings between bursts, with
// idling on both channels and a long output hold-off that fills the block.
// -----------------------------------------------------------------------------
`default_nettype none

module feedback_delay_line_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES   = 6;
   localparam int LATENCY_CYCLES = 4;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 1300000;
   localparam int IDLE_PERCENT   = 31;

   // Index 3 has no register behind it; writes there must change nothing.
   localparam logic [fdl_pkg::CSR_IDX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   localparam logic signed [fdl_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
      {1'b0, {(fdl_pkg::SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [fdl_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
      {1'b1, {(fdl_pkg::SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic [fdl_pkg::CHAN_BITS-1:0]          chan;
      logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample;
   } echo_beat_type;

   logic clock;
   logic reset;

   fdl_req_if req_bus ();
   fdl_rsp_if rsp_bus ();
   fdl_csr_if csr_bus ();

   feedback_delay_line_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Shadow copy of the delay ring and the register settings.
   bit signed [fdl_pkg::SAMPLE_BITS-1:0] ring_copy [fdl_pkg::CHANNELS][fdl_pkg::RING_DEPTH];
   int unsigned                          write_pos [fdl_pkg::CHANNELS];
   logic [fdl_pkg::DELAY_BITS-1:0]       delay_len;
   logic [fdl_pkg::GAIN_BITS-1:0]        fb_gain;
   logic signed [fdl_pkg::GAIN_BITS-1:0] out_gain;

   echo_beat_type pending_echoes[$];
   int            error_count;
   int            stall_cycles;
   bit            sender_idle_on;
   bit            receiver_idle_on;
   bit            hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [fdl_pkg::SAMPLE_BITS-1:0] clamp_sample(input longint v);
      if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
      return v[fdl_pkg::SAMPLE_BITS-1:0];
   endfunction

   // Q1.15 product rounded to nearest, ties towards plus infinity.
   function automatic longint q15_scale(input longint delayed, input longint gain);
      return (delayed * gain + 64'sd16384) >>> fdl_pkg::Q15_SHIFT;
   endfunction

   function automatic logic signed [fdl_pkg::SAMPLE_BITS-1:0] comb_filter_step(
      input logic [fdl_pkg::CHAN_BITS-1:0]          ch,
      input logic signed [fdl_pkg::SAMPLE_BITS-1:0] s
   );
      int unsigned wp;
      int unsigned rp;
      longint      delayed;
      logic signed [fdl_pkg::SAMPLE_BITS-1:0] stored;
      if (delay_len == '0) return s;
      wp = write_pos[ch];
      rp = (wp + fdl_pkg::RING_DEPTH - (int'(delay_len) % fdl_pkg::RING_DEPTH))
           % fdl_pkg::RING_DEPTH;
      delayed = ring_copy[ch][rp];
      stored = clamp_sample(longint'(s) + q15_scale(delayed, longint'({1'b0, fb_gain})));
      ring_copy[ch][wp] = stored;
      write_pos[ch] = (wp + 1) % fdl_pkg::RING_DEPTH;
      return clamp_sample(longint'(s) - q15_scale(delayed, longint'(out_gain)));
   endfunction

   function automatic logic signed [fdl_pkg::SAMPLE_BITS-1:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return SAMPLE_MAX;
      if (roll < 16) return SAMPLE_MIN;
      if (roll < 40) return fdl_pkg::SAMPLE_BITS'($signed($urandom_range(8191)) - 4096);
      return fdl_pkg::SAMPLE_BITS'($urandom);
   endfunction

   task automatic write_register(input logic [fdl_pkg::CSR_IDX_BITS-1:0] idx,
                                 input logic [fdl_pkg::CSR_DATA_BITS-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         fdl_pkg::CSR_DELAY_SAMPLES: delay_len = value[fdl_pkg::DELAY_BITS-1:0];
         fdl_pkg::CSR_FEEDBACK_GAIN: fb_gain   = value[fdl_pkg::GAIN_BITS-1:0];
         fdl_pkg::CSR_DELAY_GAIN:    out_gain  = $signed(value[fdl_pkg::GAIN_BITS-1:0]);
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Bit 16 of the gain writes lies outside the register and is set at random.
   task automatic apply_settings(input logic [fdl_pkg::DELAY_BITS-1:0] delay,
                                 input logic [fdl_pkg::GAIN_BITS-1:0]  fb,
                                 input logic [fdl_pkg::GAIN_BITS-1:0]  dg);
      write_register(fdl_pkg::CSR_DELAY_SAMPLES, delay);
      write_register(fdl_pkg::CSR_FEEDBACK_GAIN, {1'($urandom_range(1)), fb});
      write_register(fdl_pkg::CSR_DELAY_GAIN, {1'($urandom_range(1)), dg});
   endtask

   // Valid stays high into the next call unless this beat is followed by idling.
   task automatic send_sample(input logic [fdl_pkg::CHAN_BITS-1:0]          ch,
                              input logic signed [fdl_pkg::SAMPLE_BITS-1:0] s);
      echo_beat_type beat;
      req_bus.valid     <= 1'b1;
      req_bus.chan      <= ch;
      req_bus.sample_in <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beat.chan   = ch;
      beat.sample = comb_filter_step(ch, s);
      pending_echoes.push_back(beat);
      while (sender_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_random(input int count);
      repeat (count) send_sample(fdl_pkg::CHAN_BITS'($urandom_range(1)), pick_sample());
   endtask

   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_echoes.size() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   task automatic test_bypass();
      apply_settings('0, 16'd32768, 16'h7FFF);
      send_sample(1'b0, SAMPLE_MAX);
      send_sample(1'b1, SAMPLE_MIN);
      send_sample(1'b0, '0);
      send_sample(1'b1, -24'sd1);
      send_sample(1'b0, 24'sh5A5A5A);
      wait_until_idle();
   endtask

   task automatic test_unit_delay();
      apply_settings(17'd1, 16'd32768, 16'h7FFF);
      send_sample(1'b0, SAMPLE_MAX);
      send_sample(1'b0, SAMPLE_MAX);
      send_sample(1'b1, SAMPLE_MIN);
      send_sample(1'b1, 24'sd3);
      wait_until_idle();
      // Most negative output gain drives the result hard into both rails.
      apply_settings(17'd1, 16'd0, 16'h8000);
      send_sample(1'b0, SAMPLE_MAX);
      send_sample(1'b1, SAMPLE_MIN);
      send_sample(1'b0, '0);
      send_sample(1'b1, 24'sh0000FF);
      wait_until_idle();
   endtask

   task automatic test_feedback_above_unity();
      apply_settings(17'd2, 16'hFFFF, 16'h4000);
      send_sample(1'b0, 24'sh400000);
      send_sample(1'b0, -24'sh400000);
      send_sample(1'b0, 24'sd1);
      send_sample(1'b0, '0);
      send_sample(1'b1, SAMPLE_MIN);
      wait_until_idle();
   endtask

   task automatic test_longest_delay();
      apply_settings({fdl_pkg::DELAY_BITS{1'b1}}, 16'hFFFF, 16'h8000);
      send_sample(1'b0, SAMPLE_MAX);
      send_sample(1'b1, SAMPLE_MIN);
      send_sample(1'b0, 24'sh123456);
      wait_until_idle();
   endtask

   task automatic test_unmapped_register();
      apply_settings(17'd3, 16'd12000, 16'hC000);
      write_register(CSR_UNMAPPED, fdl_pkg::CSR_DATA_BITS'($urandom));
      write_register(CSR_UNMAPPED, {fdl_pkg::CSR_DATA_BITS{1'b1}});
      send_sample(1'b0, 24'sh200000);
      send_sample(1'b1, -24'sh100000);
      wait_until_idle();
   endtask

   task automatic test_random_phases(input int phases, input int beats_per_phase);
      logic [fdl_pkg::DELAY_BITS-1:0] delay;
      logic [fdl_pkg::GAIN_BITS-1:0]  fb;
      int unsigned                    roll;
      for (int p = 0; p < phases; p++) begin
         roll = $urandom_range(99);
         if (roll < 10) delay = '0;
         else if (roll < 75) delay = fdl_pkg::DELAY_BITS'($urandom_range(48, 1));
         else if (roll < 90) delay = fdl_pkg::DELAY_BITS'($urandom_range(4000, 49));
         else delay = fdl_pkg::DELAY_BITS'($urandom_range(131071, 100000));
         roll = $urandom_range(99);
         if (roll < 35) fb = fdl_pkg::GAIN_BITS'($urandom_range(32768));
         else if (roll < 50) fb = 16'd32768;
         else fb = fdl_pkg::GAIN_BITS'($urandom);
         apply_settings(delay, fb, fdl_pkg::GAIN_BITS'($urandom));
         send_random(beats_per_phase);
         wait_until_idle();
      end
   endtask

   // The output is held off while input beats keep coming, so the block backs up.
   task automatic test_output_hold_off();
      apply_settings(17'd5, 16'd30000, 16'h9000);
      sender_idle_on = 1'b0;
      hold_request = 1'b1;
      send_random(100);
      sender_idle_on = 1'b1;
      wait_until_idle();
   endtask

   task automatic test_no_idling();
      apply_settings(17'd7, 16'd40000, 16'h3000);
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      send_random(230);
      wait_until_idle();
      sender_idle_on = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   initial begin
      sender_idle_on    = 1'b1;
      receiver_idle_on  = 1'b1;
      hold_request      = 1'b0;
      error_count       = 0;
      delay_len         = '0;
      fb_gain           = '0;
      out_gain          = '0;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.chan      <= '0;
      req_bus.sample_in <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= '0;
      csr_bus.data      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bypass();
      test_unit_delay();
      test_feedback_above_unity();
      test_longest_delay();
      test_unmapped_register();
      test_random_phases(6, 110);
      test_output_hold_off();
      test_no_idling();
      test_random_phases(6, 110);

      if (pending_echoes.size() != 0) begin
         $error("%0d expected output beats never arrived", pending_echoes.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_bus.ready <= !receiver_idle_on || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      echo_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_echoes.size() == 0) begin
            $error("output beat with nothing expected: chan_out %0d sample_out %0d",
                   rsp_bus.chan_out, rsp_bus.sample_out);
            error_count++;
         end else begin
            want = pending_echoes.pop_front();
            if (rsp_bus.chan_out !== want.chan) begin
               $error("chan_out: expected %0d, actual %0d", want.chan, rsp_bus.chan_out);
               error_count++;
            end
            if (rsp_bus.sample_out !== want.sample) begin
               $error("sample_out: expected %0d, actual %0d", want.sample,
                      rsp_bus.sample_out);
               error_count++;
            end
         end
      end
   end

   // The store clear after reset keeps the input stalled for a long while, so the
   // limit is set well above that.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

`default_nettype wire
